### rtl/tmph_pkg.sv
// Shared constants, widths and the sequencer state type of the trimmed-mean pH filter.
// Used by the top level, the shared divider and the port checker. No dependencies.
package tmph_pkg;

    localparam int WINDOW      = 40;
    localparam int PTR_W       = $clog2(WINDOW);

    localparam int ADC_W       = 10;
    localparam int Q8_W        = 18;
    localparam int PH_W        = 12;
    localparam int OFS_W       = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam int ADC_MAX     = 1023;
    localparam int SUM_W       = $clog2(WINDOW * ADC_MAX + 1);
    localparam int TRIM_W      = $clog2((WINDOW - 2) * ADC_MAX + 1);

    // Both outputs are a quotient by the number of kept samples.
    localparam int DIV_D       = WINDOW - 2;
    localparam int FRAC_W      = 8;
    localparam int NUM_W       = TRIM_W + FRAC_W;

    // Rounded-up reciprocal of the kept count; its error is small enough that the floor
    // of the scaled product equals the true quotient for every NUM_W-bit numerator.
    localparam int     RECIP_SHIFT = NUM_W + $clog2(DIV_D);
    localparam int     RECIP_W     = NUM_W + 1;
    localparam longint DIV_RECIP   = ((longint'(1) << RECIP_SHIFT) + DIV_D - 1) / DIV_D;

    // pH scale: 3.5 pH/V over 5 V full scale is 1750/1024 hundredths per code.
    localparam int PH_SCALE    = 1750;
    localparam int PH_SCALE_W  = 11;
    localparam int PH_SHIFT    = 10;
    localparam int PROD_W      = TRIM_W + PH_SCALE_W;

    localparam logic [OFS_W-1:0] OFS_RESET = 9'd16;
    localparam logic [Q8_W-1:0]  Q8_MAX    = 18'd261888;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_TRIM,
        ST_MUL,
        ST_DIV1,
        ST_DIV2,
        ST_DONE
    } tmph_state_t;

endpackage

### rtl/tmph_div.sv
// Divider by the constant DIV_D through a multiply by its rounded-up reciprocal.
// Depends on tmph_pkg for widths, the reciprocal and its shift.
module tmph_div
    import tmph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int MULT_W = NUM_W + RECIP_W;

    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quot_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MULT_W-1:0] mult;

    assign mult = MULT_W'(num_reg) * MULT_W'(DIV_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start && !busy_reg;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
            num_reg <= numer;
        if (busy_reg)
            quot_reg <= NUM_W'(mult >> RECIP_SHIFT);
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

### rtl/trimmed_mean_ph_filter.sv
// Top level of the trimmed-mean pH filter: sample ring, scan sequencer and output stage.
// Depends on tmph_pkg and instantiates the shared divider tmph_div.
//
//  Channel   Direction  Payload (low bit up)                         Accepted when
//  s_axis    in         tdata: adc_sample[9:0]                       tvalid & tready
//  m_axis    out        tdata: trimmed_mean_q8[17:0], ph_centi[29:18] tvalid & tready
//  cfg       in         cfg_wr_data: ph_offset_centi[8:0]            cfg_wr_en
//
// Between a sample's transaction and the earliest next one lie one pass over the ring
// memory, one read per cycle, then two passes through the reciprocal-multiply divider.
// tready is high only in the idle state; a finished result waits in the output register
// and the next sample is accepted meanwhile. A result that finds the previous one still
// waiting holds the sequencer until the output register frees up. The ring reads as zero
// after reset through per-entry valid bits, so no clearing pass is needed. Reset is
// asynchronous, active low.
module trimmed_mean_ph_filter
    import tmph_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // adc_sample[9:0], zero padding above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // trimmed_mean_q8[17:0], ph_centi[29:18], zero padding above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_wr_en,
    input  logic [OFS_W-1:0]       cfg_wr_data
);

    tmph_state_t       state_reg, state_next;

    logic [ADC_W-1:0]  ring_mem [WINDOW];
    logic [WINDOW-1:0] ring_vld_reg;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [ADC_W-1:0]  rd_data_reg;
    logic              rd_bit_reg;
    logic              rd_vld_reg;
    logic              rd_first_reg;
    logic              rd_issue;

    logic [SUM_W-1:0]  sum_reg;
    logic [ADC_W-1:0]  lo_reg, hi_reg;
    logic [ADC_W-1:0]  sample;
    logic [TRIM_W-1:0] trim_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]  q1_reg;

    logic [OFS_W-1:0]  offset_reg;
    logic [Q8_W-1:0]   mean_reg;
    logic [PH_W-1:0]   ph_reg;
    logic [PH_W-1:0]   ph_sum;
    logic              m_valid_reg, m_valid_next;

    logic              accept;
    logic              div_start;
    logic [NUM_W-1:0]  div_numer;
    logic [NUM_W-1:0]  div_quot;
    logic              div_done;
    logic              q1_load;
    logic              out_load;

    tmph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .quot  (div_quot),
        .done  (div_done)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rd_issue      = (state_reg == ST_SCAN);
    assign wp_next       = (wp_reg == PTR_W'(WINDOW - 1)) ? '0 : wp_reg + PTR_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        rd_addr_next = rd_addr_reg;
        div_start    = 1'b0;
        div_numer    = '0;
        q1_load      = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr_next = '0;
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (rd_addr_reg == PTR_W'(WINDOW - 1))
                begin
                    rd_addr_next = '0;
                    state_next   = ST_SCAN_END;
                end
                else
                    rd_addr_next = rd_addr_reg + PTR_W'(1);
            end
            ST_SCAN_END:
                state_next = ST_TRIM;
            ST_TRIM:
                state_next = ST_MUL;
            ST_MUL:
            begin
                div_start  = 1'b1;
                div_numer  = {trim_reg, {FRAC_W{1'b0}}};
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    // Flooring in two steps gives the same quotient as one division
                    // by 1024 times the kept count.
                    q1_load    = 1'b1;
                    div_start  = 1'b1;
                    div_numer  = NUM_W'(prod_reg >> PH_SHIFT);
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            rd_addr_reg  <= '0;
            ring_vld_reg <= '0;
            rd_bit_reg   <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            offset_reg   <= OFS_RESET;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_addr_reg  <= rd_addr_next;
            rd_bit_reg   <= ring_vld_reg[rd_addr_reg];
            rd_vld_reg   <= rd_issue;
            rd_first_reg <= rd_issue && (rd_addr_reg == '0);
            m_valid_reg  <= m_valid_next;
            if (accept)
            begin
                wp_reg               <= wp_next;
                ring_vld_reg[wp_reg] <= 1'b1;
            end
            if (cfg_wr_en)
                offset_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ring_mem[wp_reg] <= s_axis_tdata[ADC_W-1:0];
        rd_data_reg <= ring_mem[rd_addr_reg];
    end

    // Entries never written since reset count as zero samples.
    assign sample = rd_bit_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (rd_first_reg)
            begin
                sum_reg <= SUM_W'(sample);
                lo_reg  <= sample;
                hi_reg  <= sample;
            end
            else
            begin
                sum_reg <= sum_reg + SUM_W'(sample);
                if (sample < lo_reg)
                    lo_reg <= sample;
                if (sample > hi_reg)
                    hi_reg <= sample;
            end
        end
        if (state_reg == ST_TRIM)
            trim_reg <= TRIM_W'(sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg));
        if (state_reg == ST_MUL)
            prod_reg <= PROD_W'(trim_reg) * PROD_W'(PH_SCALE);
        if (q1_load)
            q1_reg <= div_quot;
        if (out_load)
        begin
            mean_reg <= Q8_W'(q1_reg);
            ph_reg   <= ph_sum;
        end
    end

    assign ph_sum = PH_W'(div_quot) + {{(PH_W - OFS_W){offset_reg[OFS_W-1]}}, offset_reg};

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - Q8_W - PH_W){1'b0}}, ph_reg, mean_reg};

endmodule

### rtl/tmph_checker.sv
// Port-level checker for the trimmed-mean pH filter, with its bind to the top level.
// Depends on tmph_pkg for field widths and the largest trimmed mean.
module tmph_port_checker
    import tmph_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready
);

    // A sample transaction starts a multi-cycle pass, so no second one can follow at once.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a sample was still being processed");

    // No result can appear in the cycle right after a sample transaction.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared without the window pass");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // The mean of 10-bit samples with 8 fraction bits never exceeds full scale.
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[Q8_W-1:0] <= Q8_MAX)
                          && (m_axis_tdata[OUT_TDATA_W-1:Q8_W+PH_W] == '0))
        else $error("trimmed mean out of range or padding bits set");

endmodule

bind trimmed_mean_ph_filter tmph_port_checker u_tmph_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

### sim/tmph_checker.sv
`timescale 1ns / 100ps
// Checker for the trimmed-mean pH filter. It watches the sample, result and offset channels,
// keeps its own copy of the sample window and predicts every result. Depends on tmph_pkg.
module tmph_checker
    import tmph_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_wr_en,
    input  logic [OFS_W-1:0]       cfg_wr_data,
    output int                     mismatch_count,
    output int                     readings_pending
);

    typedef struct packed {
        logic [PH_W-1:0] ph_centi;
        logic [Q8_W-1:0] mean_q8;
    } reading_t;

    logic [ADC_W-1:0]        window_copy [WINDOW];
    int                      next_slot;
    logic signed [OFS_W-1:0] ph_offset;
    reading_t                expected_readings [$];
    int                      errors;

    assign mismatch_count = errors;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
        errors++;
    endtask

    // Stores one sample in the window and queues the reading that it must produce.
    task automatic absorb_sample(input logic [ADC_W-1:0] sample);
        int       total;
        int       lowest;
        int       highest;
        int       trimmed;
        int       ph;
        reading_t r;
        window_copy[next_slot] = sample;
        next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
        total   = 0;
        lowest  = window_copy[0];
        highest = window_copy[0];
        for (int i = 0; i < WINDOW; i++)
        begin
            total += window_copy[i];
            if (window_copy[i] < lowest)
                lowest = window_copy[i];
            if (window_copy[i] > highest)
                highest = window_copy[i];
        end
        // Only one copy of the smallest and of the largest value leaves the sum.
        trimmed = total - lowest - highest;
        ph = (trimmed * PH_SCALE) / (1024 * (WINDOW - 2)) + int'(ph_offset);
        r.mean_q8  = Q8_W'((trimmed * 256) / (WINDOW - 2));
        r.ph_centi = PH_W'(ph);
        expected_readings.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        reading_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                window_copy[i] = '0;
            next_slot = 0;
            ph_offset = OFS_RESET;
            expected_readings.delete();
            errors = 0;
            readings_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                ph_offset = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                absorb_sample(s_axis_tdata[ADC_W-1:0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = reading_t'(m_axis_tdata[Q8_W+PH_W-1:0]);
                if (expected_readings.size() == 0)
                    report_mismatch("result transactions without a sample", 0, 1);
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.mean_q8 !== want.mean_q8)
                        report_mismatch("trimmed_mean_q8", int'(want.mean_q8),
                                        int'(got.mean_q8));
                    if (got.ph_centi !== want.ph_centi)
                        report_mismatch("ph_centi", int'($signed(want.ph_centi)),
                                        int'($signed(got.ph_centi)));
                end
            end
            readings_pending <= expected_readings.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the trimmed-mean pH filter: clock, reset, sample and offset stimulus,
// result backpressure and the verdict. Depends on tmph_pkg, trimmed_mean_ph_filter, tmph_checker.
module tb;
    import tmph_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 140;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [OFS_W-1:0]       cfg_wr_data   = '0;

    int mismatch_count;
    int readings_pending;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int quiet_cycles      = 0;

    trimmed_mean_ph_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    tmph_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .mismatch_count   (mismatch_count),
        .readings_pending (readings_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Ends the run when no transaction of any kind has happened for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [OFS_W-1:0] OFS_WIDTH_RANDOM();
        return OFS_W'($urandom);
    endfunction

    // Called right after a rising edge; returns right after the edge that accepted the sample.
    task automatic send_sample(input logic [ADC_W-1:0] sample);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= IN_TDATA_W'(sample);
        s_axis_tvalid <= 1'b1;
        @(posedge clk iff s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_offset(input logic signed [OFS_W-1:0] offset);
        cfg_wr_data <= offset;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Runs of random samples, steady levels with noise and the odd spike, flat extremes
    // and alternating extremes, so that the window fills up with known shapes.
    task automatic run_samples(input int count);
        int               sent;
        int               kind;
        int               run_len;
        int               level;
        int               noisy;
        logic [ADC_W-1:0] sample;
        sent = 0;
        while (sent < count)
        begin
            kind    = int'($urandom_range(0, 9));
            run_len = (kind < 3) ? int'($urandom_range(1, 20))
                                 : int'($urandom_range(WINDOW, WINDOW + 8));
            level   = int'($urandom_range(0, ADC_MAX));
            if (kind == 6)
                level = ADC_MAX;
            else if (kind == 7)
                level = 0;
            for (int i = 0; i < run_len && sent < count; i++)
            begin
                case (kind)
                    0, 1, 2: sample = ADC_W'($urandom_range(0, ADC_MAX));
                    6, 7:    sample = ADC_W'(level);
                    8:       sample = i[0] ? ADC_W'(ADC_MAX) : '0;
                    9:       sample = ADC_W'($urandom);
                    default:
                    begin
                        noisy = level + int'($urandom_range(0, 16)) - 8;
                        if (noisy < 0)
                            noisy = 0;
                        else if (noisy > ADC_MAX)
                            noisy = ADC_MAX;
                        if ($urandom_range(0, 7) == 0)
                            noisy = int'($urandom_range(0, ADC_MAX));
                        sample = ADC_W'(noisy);
                    end
                endcase
                send_sample(sample);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic signed [OFS_W-1:0] offsets [8];
        logic [ADC_W-1:0]        opening [20];
        offsets = '{-9'sd256, 9'sd255, -9'sd200, 9'sd200, 9'sd0, -9'sd1, 9'sd0, 9'sd16};
        offsets[6] = OFS_WIDTH_RANDOM();
        opening = '{10'd1023, 10'd1023, 10'd0, 10'd682, 10'd341, 10'd1, 10'd1022, 10'd512,
                    10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd511, 10'd256, 10'd768,
                    10'd1023, 10'd2, 10'd1000, 10'd0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zeros from reset still sit in the window; single and repeated extremes go in first.
        foreach (opening[i])
            send_sample(opening[i]);
        drain_results();

        for (int p = 0; p < 8; p++)
        begin
            sender_idle_pct   <= (p % 4 == 1) ? 71 : (p % 4 == 3) ? 25 : 0;
            receiver_idle_pct <= (p % 4 == 2) ? 71 : (p % 4 == 3) ? 25 : 0;
            write_offset(offsets[p]);
            run_samples(PHASE_ITEMS);
            drain_results();
        end

        repeat (150) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
